// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// types, sizes and codes of the sysex frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	localparam int PAYLOAD_DEPTH = 16;
	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
	localparam int HDR_LEN = 6;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;
	localparam logic KIND_CMD = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic [7:0] SYX_START = 8'hf0;
	localparam logic [7:0] SYX_END = 8'hf7;
	localparam logic [7:0] RT_FIRST = 8'hf8;

	typedef struct packed {
		logic opcode;
		logic [7:0] port;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] frame_port;
		logic item_kind;
		logic [7:0] item_byte;
		logic [4:0] payload_count;
		logic command_known;
		logic last_item;
	} out_beat_t;

	// expected header byte at a position below HDR_LEN
	function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0: b = SYX_START;
			3'd1: b = 8'h00;
			3'd2: b = 8'h00;
			3'd3: b = 8'h7e;
			3'd4: b = 8'h4f;
			3'd5: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// one of the fourteen defined command codes
	function automatic logic cmd_known(input logic [7:0] code);
		logic k;
		case (code)
			8'h01, 8'h10, 8'h11, 8'h20, 8'h30, 8'h31, 8'h32,
			8'h40, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: hdl/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/sysex_frame_deframer.sv
// ----------------------------------------------------------------------------
// sysex_frame_deframer
// hunts for the header f0 00 00 7e 4f 54 on a tagged midi byte stream, keeps
// the command byte and up to PAYLOAD_DEPTH payload bytes, and on f7 sends a
// command item followed by one item per stored payload byte
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 beat type
//  byte_*    in         byte_valid / byte_stall   in_beat_t (opcode, port, data_byte)
//  item_*    out        item_valid / item_stall   out_beat_t (frame_port .. last_item)
//
//  a byte or timeout beat is taken while the block is parsing
//  an f7 that closes a frame holds the input stalled during readout: first
//  the command item, then one item per payload byte; each ram read is issued
//  while the previous item is loaded, so only item_stall slows the readout
//  readout of n payload bytes keeps the byte side stalled until the command
//  item and all n data items are loaded
//  reset clears the parser state and the output valid; the ram is not cleared,
//  only entries written in the current frame are ever read
//
`default_nettype none
`include "assert_macros.svh"

module sysex_frame_deframer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_valid,
	output logic byte_stall,
	input wire sfd_pkg::in_beat_t byte_beat,
	output logic item_valid,
	input wire logic item_stall,
	output sfd_pkg::out_beat_t item_beat
);

	import sfd_pkg::*;

	// parser phase of the frame
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_COMMAND,
		PH_PAYLOAD
	} phase_t;

	// block level sequencing: parsing or frame readout
	typedef enum logic [1:0] {
		S_RUN,
		S_CMD,
		S_DATA
	} state_t;

	state_t state_q;
	phase_t phase_q, phase_d;
	logic [2:0] hpos_q, hpos_d;
	logic [7:0] cmd_q, cmd_d;
	logic [CNT_W-1:0] stored_q, stored_d;
	logic [7:0] prev_port_q;
	logic [7:0] frame_port_q;
	logic known_q;
	logic [CNT_W-1:0] idx_q;

	logic byte_take;
	logic out_free;
	logic item_load;
	logic close_frame;
	logic wr_en;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0] rd_data;
	logic [7:0] b;
	logic [7:0] port;
	phase_t ph_in;
	logic [2:0] hpos_in;

	assign byte_stall = (state_q != S_RUN);
	assign byte_take = byte_valid && !byte_stall;
	assign out_free = !item_valid || !item_stall;
	// an item is loaded in either readout state once the output register is free
	assign item_load = (state_q == S_CMD || state_q == S_DATA) && out_free;
	assign b = byte_beat.data_byte;
	assign port = byte_beat.port;

	// ------------------------------------------------------------------------
	// parser: next phase for one accepted byte
	// ------------------------------------------------------------------------
	always_comb begin
		phase_d = phase_q;
		hpos_d = hpos_q;
		cmd_d = cmd_q;
		stored_d = stored_q;
		wr_en = 1'b0;
		close_frame = 1'b0;
		// a non-real-time byte on another port abandons the frame in progress
		if (phase_q != PH_IDLE && port != prev_port_q) begin
			ph_in = PH_IDLE;
			hpos_in = 3'd0;
		end else begin
			ph_in = phase_q;
			hpos_in = hpos_q;
		end
		if (byte_beat.opcode == OP_TIMEOUT) begin
			if (port == prev_port_q) begin
				phase_d = PH_IDLE;
				hpos_d = 3'd0;
			end
		end else if (b >= RT_FIRST) begin
			// real-time bytes pass by untouched
		end else if (b[7] && b != SYX_START && b != SYX_END) begin
			phase_d = PH_IDLE;
			hpos_d = 3'd0;
		end else begin
			phase_d = ph_in;
			hpos_d = hpos_in;
			case (ph_in)
				PH_IDLE: begin
					if (b == hdr_byte(3'd0)) begin
						phase_d = PH_HEADER;
						hpos_d = 3'd1;
					end
				end
				PH_HEADER: begin
					if (hpos_in >= 3'(HDR_LEN) || b != hdr_byte(hpos_in)) begin
						phase_d = PH_IDLE;
						hpos_d = 3'd0;
					end else begin
						hpos_d = hpos_in + 3'd1;
						if (hpos_in + 3'd1 >= 3'(HDR_LEN)) begin
							phase_d = PH_COMMAND;
						end
					end
				end
				PH_COMMAND: begin
					cmd_d = b;
					stored_d = '0;
					phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (b == SYX_END) begin
						close_frame = 1'b1;
						phase_d = PH_IDLE;
						hpos_d = 3'd0;
					end else if (stored_q < CNT_W'(PAYLOAD_DEPTH)) begin
						wr_en = 1'b1;
						stored_d = stored_q + CNT_W'(1);
					end
				end
				default: begin
					phase_d = PH_IDLE;
					hpos_d = 3'd0;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// readout: issue the next ram read while the current item is loaded
	// ------------------------------------------------------------------------
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_CMD: begin
				rd_en = out_free && (stored_q != '0);
				rd_addr = '0;
			end
			S_DATA: begin
				rd_en = out_free && (idx_q + CNT_W'(1) < stored_q);
				rd_addr = ADDR_W'(idx_q + CNT_W'(1));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	sfd_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_payload_ram (
		.clk(clk),
		.wr_en(byte_take && wr_en),
		.wr_addr(ADDR_W'(stored_q)),
		.wr_data(b),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// ------------------------------------------------------------------------
	// state, parser registers and the output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			phase_q <= PH_IDLE;
			hpos_q <= 3'd0;
			cmd_q <= 8'd0;
			stored_q <= '0;
			prev_port_q <= 8'd0;
			frame_port_q <= 8'd0;
			known_q <= 1'b0;
			idx_q <= '0;
			item_valid <= 1'b0;
			item_beat <= '0;
		end else begin
			if (item_load) begin
				item_valid <= 1'b1;
			end else if (!item_stall) begin
				item_valid <= 1'b0;
			end
			case (state_q)
				S_RUN: begin
					if (byte_take) begin
						phase_q <= phase_d;
						hpos_q <= hpos_d;
						cmd_q <= cmd_d;
						stored_q <= stored_d;
						if (byte_beat.opcode == OP_BYTE && b < RT_FIRST) begin
							prev_port_q <= port;
						end
						if (close_frame) begin
							frame_port_q <= port;
							known_q <= cmd_known(cmd_q);
							state_q <= S_CMD;
						end
					end
				end
				S_CMD: begin
					if (out_free) begin
						item_beat.frame_port <= frame_port_q;
						item_beat.item_kind <= KIND_CMD;
						item_beat.item_byte <= cmd_q;
						item_beat.payload_count <= 5'(stored_q);
						item_beat.command_known <= known_q;
						item_beat.last_item <= (stored_q == '0);
						idx_q <= '0;
						state_q <= (stored_q == '0) ? S_RUN : S_DATA;
					end
				end
				S_DATA: begin
					if (out_free) begin
						item_beat.item_kind <= KIND_DATA;
						item_beat.item_byte <= rd_data;
						item_beat.last_item <= (idx_q + CNT_W'(1) == stored_q);
						idx_q <= idx_q + CNT_W'(1);
						if (idx_q + CNT_W'(1) == stored_q) begin
							state_q <= S_RUN;
						end
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	// payload ram is never written during readout
	`ASSERT_AT(a_no_wr_in_readout, clk, arst_n, state_q == S_RUN || !(byte_take && wr_en))
	// data readout only runs over stored entries
	`ASSERT_AT(a_idx_in_range, clk, arst_n, state_q != S_DATA || idx_q < stored_q)
	// the command item leads every frame
	`ASSERT_NEXT(a_cmd_first, clk, arst_n, state_q == S_CMD && out_free,
		item_valid && item_beat.item_kind == KIND_CMD)
	// a data item is loaded from the ram read issued while the previous item was loaded
	`ASSERT_NEXT(a_data_from_ram, clk, arst_n, state_q == S_DATA && out_free,
		item_valid && item_beat.item_kind == KIND_DATA)

endmodule

`default_nettype wire
